// ===== hw/rtl/hem_pkg.sv =====
package hem_pkg;

  // Default sizes of the table and of the cumulative counts
  localparam int LevelsDef    = 256;
  localparam int CountBitsDef = 21;

  // Fixed field widths
  localparam int BinCountW = 21;
  localparam int LevelW    = 8;

  // Quotient bits per map: the result never exceeds 2^LevelW - 1
  localparam int DivSteps = LevelW;

  // Opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_MAP     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY      = 2'd2;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [BinCountW-1:0] bin_count;
    logic [LevelW-1:0]    pixel_level;
  } hem_in_t;

  typedef struct packed {
    logic [LevelW-1:0] mapped_level;
    logic [1:0]        status;
  } hem_out_t;

  typedef enum logic [1:0] {
    HEM_IDLE,
    HEM_READ,
    HEM_DIV
  } hem_state_e;

endpackage

// ===== hw/rtl/hem_ram.sv =====
module hem_ram #(
  parameter int Width = 21,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/histogram_equalization_map.sv =====
// Load and restart beats: accepted every cycle while not busy, no result.
// Map beat on a loaded, non-empty table: a table read state, then the divide
// steps of the shared restoring subtract/compare unit; busy is high in both,
// so no new beat is accepted, and the result strobe follows the last step.
// Map beat with status not-loaded or empty: strobe in the next cycle; no stall.
// Reset (async, active low) clears the total and bin count; table is unknown.
module histogram_equalization_map #(
  parameter int LEVELS     = hem_pkg::LevelsDef,
  parameter int COUNT_BITS = hem_pkg::CountBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hem_pkg::hem_in_t  in_i,
  output logic              res_strobe_o,
  output hem_pkg::hem_out_t result_o
);

  import hem_pkg::*;

  localparam int IdxW   = $clog2(LEVELS);
  localparam int BinsW  = $clog2(LEVELS + 1);
  localparam int SumW   = ((COUNT_BITS > BinCountW) ? COUNT_BITS : BinCountW) + 1;
  localparam int ProdW  = COUNT_BITS + LevelW;
  localparam int CntW   = $clog2(DivSteps);

  hem_state_e state_q, state_d;

  logic [COUNT_BITS-1:0] total_q, total_d;
  logic [BinsW-1:0]      bins_q, bins_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [LevelW-1:0]     lo_q, lo_d;
  logic [LevelW-1:0]     quo_q, quo_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  strobe_q, strobe_d;
  hem_out_t              res_q, res_d;

  logic                  accept;
  logic                  loaded;
  logic                  total_zero;
  logic                  map_go;
  logic                  last_step;
  logic [IdxW-1:0]       map_idx;
  logic [SumW-1:0]       sum_wide;
  logic [COUNT_BITS-1:0] sum_sat;
  logic [ProdW-1:0]      prod;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  qbit;

  logic                  ram_we;
  logic [COUNT_BITS-1:0] ram_rdata;

  assign accept     = start && !busy;
  assign loaded     = (bins_q == BinsW'(LEVELS));
  assign total_zero = (total_q == '0);
  assign map_go     = accept && (in_i.opcode == OP_MAP) && loaded && !total_zero;
  assign last_step  = (cnt_q == CntW'(DivSteps - 1));

  // Clamp the level to the last table entry
  always_comb begin
    if (32'(in_i.pixel_level) >= LEVELS) begin
      map_idx = IdxW'(LEVELS - 1);
    end else begin
      map_idx = IdxW'(in_i.pixel_level);
    end
  end

  // Saturating accumulate of the next bin
  assign sum_wide = SumW'(total_q) + SumW'(in_i.bin_count);
  assign sum_sat  = (sum_wide > SumW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                            : COUNT_BITS'(sum_wide);

  // Cumulative count times 255 as a shift and subtract
  assign prod = {ram_rdata, LevelW'(0)} - ProdW'(ram_rdata);

  // Shared restoring divide step: one quotient bit per cycle
  assign trial = {rem_q, lo_q[LevelW-1]};
  assign diff  = trial - {1'b0, total_q};
  assign qbit  = !diff[COUNT_BITS];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      HEM_IDLE: if (map_go) state_d = HEM_READ;
      HEM_READ: state_d = HEM_DIV;
      HEM_DIV:  if (last_step) state_d = HEM_IDLE;
      default:  state_d = HEM_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy   = 1'b0;
    ram_we = 1'b0;
    case (state_q)
      HEM_IDLE: ram_we = accept && (in_i.opcode == OP_LOAD) && !loaded;
      HEM_READ: busy = 1'b1;
      HEM_DIV:  busy = 1'b1;
      default:  busy = 1'b0;
    endcase
  end

  // Datapath and result next values
  always_comb begin
    total_d  = total_q;
    bins_d   = bins_q;
    rem_d    = rem_q;
    lo_d     = lo_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    case (state_q)
      HEM_IDLE: begin
        if (accept) begin
          case (in_i.opcode)
            OP_LOAD: begin
              if (!loaded) begin
                total_d = sum_sat;
                bins_d  = bins_q + BinsW'(1);
              end
            end
            OP_RESTART: begin
              total_d = '0;
              bins_d  = '0;
            end
            OP_MAP: begin
              // Answer the special cases at once
              if (!loaded) begin
                strobe_d           = 1'b1;
                res_d.mapped_level = '0;
                res_d.status       = STATUS_NOT_LOADED;
              end else if (total_zero) begin
                strobe_d           = 1'b1;
                res_d.mapped_level = '0;
                res_d.status       = STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      HEM_READ: begin
        // Top bits start below the divisor since cum <= total
        rem_d = prod[ProdW-1:LevelW];
        lo_d  = prod[LevelW-1:0];
        cnt_d = '0;
      end
      HEM_DIV: begin
        rem_d = qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        lo_d  = {lo_q[LevelW-2:0], 1'b0};
        quo_d = {quo_q[LevelW-2:0], qbit};
        cnt_d = cnt_q + CntW'(1);
        if (last_step) begin
          strobe_d           = 1'b1;
          res_d.mapped_level = {quo_q[LevelW-2:0], qbit};
          res_d.status       = STATUS_OK;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= HEM_IDLE;
      total_q  <= '0;
      bins_q   <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      bins_q   <= bins_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    res_q <= res_d;
  end

  // Cumulative table
  hem_ram #(
    .Width (COUNT_BITS),
    .Depth (LEVELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bins_q[IdxW-1:0]),
    .wdata_i (sum_sat),
    .raddr_i (map_idx),
    .rdata_o (ram_rdata)
  );

  assign res_strobe_o = strobe_q;
  assign result_o     = res_q;

  // An ok result only follows the last divide step
  a_ok_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && result_o.status == STATUS_OK) |-> $past(state_q == HEM_DIV))
    else $error("ok result without a divide");

  // A table read is always followed by the divide
  a_read_then_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == HEM_READ) |=> (state_q == HEM_DIV))
    else $error("read not followed by divide");

  // No table write while a map is in progress
  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !ram_we)
    else $error("table write while busy");

  // Bin count never passes the table size
  a_bins_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(bins_q) <= LEVELS))
    else $error("bin count overflow");

endmodule
